/* rtl/pidc_pkg.sv */
// ============================================================================
// pidc_pkg
// Shared types and constants of the PID controller with integral clamp.
// ============================================================================
`default_nettype none

package pidc_pkg;

    localparam int DATA_W   = 32;
    localparam int MS_W     = 16;
    localparam int LIM_W    = 48;
    localparam int ERR_W    = DATA_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int ISUM_W   = 50;
    localparam int DERIV_W  = DIFF_W + 1;
    localparam int DIGIT_W  = 16;
    localparam int MOP_W    = 64;
    localparam int PROD_W   = DATA_W + DIGIT_W + 1;
    localparam int ACC_W    = 84;
    localparam int SAT_W    = ACC_W - DIGIT_W;
    localparam int IDX_W    = 3;
    localparam int DIV_STEPS = DIFF_W;
    localparam int DCNT_W   = 6;
    localparam int IN_W     = DATA_W + MS_W;

    localparam logic [IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OUT_MIN    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OUT_MAX    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_INT_LIMIT  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_TARGET     = 3'd6;

    localparam logic [1:0] DIGIT_TOP_P = 2'd2;
    localparam logic [1:0] DIGIT_TOP_I = 2'd3;
    localparam logic [1:0] DIGIT_TOP_D = 2'd2;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_INTEG    = 10'b00_0000_0010,
        ST_SUM      = 10'b00_0000_0100,
        ST_CLAMP    = 10'b00_0000_1000,
        ST_MUL_P    = 10'b00_0001_0000,
        ST_MUL_I    = 10'b00_0010_0000,
        ST_WAIT_DIV = 10'b00_0100_0000,
        ST_MUL_D    = 10'b00_1000_0000,
        ST_DRAIN    = 10'b01_0000_0000,
        ST_SAT      = 10'b10_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        SEL_P = 2'd0,
        SEL_I = 2'd1,
        SEL_D = 2'd2
    } sel_t;

    typedef struct packed {
        logic              capture;
        logic              ems_mul;
        logic              div_start;
        logic              isum_add;
        logic              clamp;
        logic              acc_clr;
        logic              mul_en;
        sel_t              mul_sel;
        logic [1:0]        digit;
        logic              top;
        logic              deriv_load;
        logic              sat_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } sts_t;

    typedef struct packed {
        logic [DATA_W-1:0] prop_gain;
        logic [DATA_W-1:0] integ_gain;
        logic [DATA_W-1:0] deriv_gain;
        logic [DATA_W-1:0] out_min;
        logic [DATA_W-1:0] out_max;
        logic [LIM_W-1:0]  integral_limit;
        logic [DATA_W-1:0] target;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/pidc_ctrl.sv */
// ============================================================================
// pidc_ctrl
// Sequencer: steps the datapath through error, integral, divide, multiply
// digits and output saturation; owns the input and output handshakes.
// ============================================================================
`default_nettype none

module pidc_ctrl
    import pidc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t     state_reg, state_next;
    logic [1:0] dig_reg, dig_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        cmd            = '0;
        cmd.mul_sel    = SEL_P;
        cmd.digit      = dig_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                cmd.ems_mul   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.isum_add = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp   = 1'b1;
                cmd.acc_clr = 1'b1;
                dig_next    = 2'd0;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_P;
                cmd.top     = (dig_reg == DIGIT_TOP_P);
                dig_next    = dig_reg + 2'd1;
                if (dig_reg == DIGIT_TOP_P)
                begin
                    dig_next   = 2'd0;
                    state_next = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_I;
                cmd.top     = (dig_reg == DIGIT_TOP_I);
                dig_next    = dig_reg + 2'd1;
                if (dig_reg == DIGIT_TOP_I)
                begin
                    dig_next   = 2'd0;
                    state_next = ST_WAIT_DIV;
                end
            end
            ST_WAIT_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.deriv_load = 1'b1;
                    state_next     = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_D;
                cmd.top     = (dig_reg == DIGIT_TOP_D);
                dig_next    = dig_reg + 2'd1;
                if (dig_reg == DIGIT_TOP_D)
                begin
                    dig_next   = 2'd0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    cmd.sat_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dig_reg       <= dig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_sat_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sat_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.div_busy)
        else $error("divider busy while idle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_INTEG))
        else $error("accepted beat did not start the sequence");

    a_deriv_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_en && cmd.mul_sel == SEL_D) |-> !sts.div_busy)
        else $error("derivative digit issued before divide finished");

endmodule

`default_nettype wire

/* rtl/pidc_dp.sv */
// ============================================================================
// pidc_dp
// Datapath: error, integral clamp, restoring divider, shared 32x17
// multiplier with digit accumulator, and output saturation register.
// ============================================================================
`default_nettype none

module pidc_dp
    import pidc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire cfg_t              cfg,
    input  wire logic [DATA_W-1:0] measured_value,
    input  wire logic [MS_W-1:0]   elapsed_ms,
    output sts_t                   sts,
    output logic [DATA_W-1:0]      drive_value
);

    logic signed [ERR_W-1:0]   err_reg;
    logic [MS_W-1:0]           ms_reg;
    logic signed [ISUM_W-1:0]  ems_reg;
    logic signed [ISUM_W-1:0]  isum_raw_reg;
    logic signed [ISUM_W-1:0]  isum_reg;
    logic signed [ISUM_W-1:0]  integral_sum_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;

    logic [MS_W-1:0]           rem_reg;
    logic [DIFF_W-1:0]         quo_reg;
    logic [DCNT_W-1:0]         cnt_reg;
    logic                      busy_reg;
    logic                      neg_reg;
    logic signed [DERIV_W-1:0] deriv_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic [1:0]                pd_reg;
    logic                      pv_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [DATA_W-1:0]         drive_reg;

    logic signed [ERR_W-1:0]   err_next;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [MS_W:0]             div_sh;
    logic [MS_W+1:0]           div_trial;
    logic signed [ISUM_W-1:0]  lim_pos;
    logic signed [ISUM_W-1:0]  lim_neg;
    logic signed [ISUM_W-1:0]  isum_clamped;
    logic [DIFF_W:0]           quo_ext;
    logic [MOP_W-1:0]          mop;
    logic [DIGIT_W-1:0]        digit;
    logic signed [DIGIT_W:0]   digit_s;
    logic signed [DATA_W-1:0]  gain;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   addend;
    logic signed [SAT_W-1:0]   acc_sh;
    logic signed [SAT_W-1:0]   lo_b;
    logic signed [SAT_W-1:0]   hi_b;
    logic [DATA_W-1:0]         sat_val;

    assign err_next = $signed({cfg.target[DATA_W-1], cfg.target})
                    - $signed({measured_value[DATA_W-1], measured_value});
    assign diff     = $signed({err_reg[ERR_W-1], err_reg})
                    - $signed({prev_err_reg[ERR_W-1], prev_err_reg});
    assign diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

    assign div_sh    = {rem_reg, quo_reg[DIFF_W-1]};
    assign div_trial = {1'b0, div_sh} - {2'b00, ms_reg};

    assign lim_pos = $signed({2'b00, cfg.integral_limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (isum_raw_reg > lim_pos)
            isum_clamped = lim_pos;
        else if (isum_raw_reg < lim_neg)
            isum_clamped = lim_neg;
        else
            isum_clamped = isum_raw_reg;
    end

    assign quo_ext = {1'b0, quo_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            SEL_P:
            begin
                mop  = {{(MOP_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                gain = $signed(cfg.prop_gain);
            end
            SEL_I:
            begin
                mop  = {{(MOP_W-ISUM_W){isum_reg[ISUM_W-1]}}, isum_reg};
                gain = $signed(cfg.integ_gain);
            end
            SEL_D:
            begin
                mop  = {{(MOP_W-DERIV_W){deriv_reg[DERIV_W-1]}}, deriv_reg};
                gain = $signed(cfg.deriv_gain);
            end
            default:
            begin
                mop  = '0;
                gain = '0;
            end
        endcase
    end

    assign digit   = mop[DIGIT_W*cmd.digit +: DIGIT_W];
    assign digit_s = $signed({cmd.top & digit[DIGIT_W-1], digit});

    assign prod_ext = $signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    always_comb
    begin
        case (pd_reg)
            2'd0:    addend = prod_ext;
            2'd1:    addend = prod_ext <<< DIGIT_W;
            2'd2:    addend = prod_ext <<< (2*DIGIT_W);
            2'd3:    addend = prod_ext <<< (3*DIGIT_W);
            default: addend = prod_ext;
        endcase
    end

    assign acc_sh = acc_reg[ACC_W-1:DIGIT_W];
    assign lo_b   = $signed({{(SAT_W-DATA_W){cfg.out_min[DATA_W-1]}}, cfg.out_min});
    assign hi_b   = $signed({{(SAT_W-DATA_W){cfg.out_max[DATA_W-1]}}, cfg.out_max});

    always_comb
    begin
        if (acc_sh < lo_b)
            sat_val = cfg.out_min;
        else if (acc_sh > hi_b)
            sat_val = cfg.out_max;
        else
            sat_val = acc_sh[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_sum_reg <= '0;
            prev_err_reg     <= '0;
            busy_reg         <= 1'b0;
            cnt_reg          <= '0;
            pv_reg           <= 1'b0;
        end
        else
        begin
            if (cmd.clamp)
            begin
                integral_sum_reg <= isum_clamped;
                prev_err_reg     <= err_reg;
            end
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                    busy_reg <= 1'b0;
            end
            pv_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            err_reg <= err_next;
            ms_reg  <= elapsed_ms;
        end
        if (cmd.ems_mul)
            ems_reg <= err_reg * $signed({1'b0, ms_reg});
        if (cmd.isum_add)
            isum_raw_reg <= integral_sum_reg + ems_reg;
        if (cmd.clamp)
            isum_reg <= isum_clamped;
        if (cmd.div_start)
        begin
            quo_reg <= diff_mag;
            rem_reg <= '0;
            neg_reg <= diff[DIFF_W-1];
        end
        else if (busy_reg)
        begin
            if (!div_trial[MS_W+1])
            begin
                rem_reg <= div_trial[MS_W-1:0];
                quo_reg <= {quo_reg[DIFF_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_sh[MS_W-1:0];
                quo_reg <= {quo_reg[DIFF_W-2:0], 1'b0};
            end
        end
        if (cmd.deriv_load)
        begin
            if (ms_reg == '0)
                deriv_reg <= '0;
            else if (neg_reg)
                deriv_reg <= $signed(~quo_ext + 1'b1);
            else
                deriv_reg <= $signed(quo_ext);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= gain * digit_s;
            pd_reg   <= cmd.digit;
        end
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (pv_reg)
            acc_reg <= acc_reg + addend;
        if (cmd.sat_load)
            drive_reg <= sat_val;
    end

    assign sts.div_busy = busy_reg;
    assign drive_value  = drive_reg;

endmodule

`default_nettype wire

/* rtl/pid_controller_with_integral_clamp.sv */
// ============================================================================
// pid_controller_with_integral_clamp
// PID controller in signed Q16.16 with clamped integral and saturated drive.
// ============================================================================
// Usage:
//   Write gains, limits and target on the cfg channel (index 0..6) while the
//   block is idle; cfg_ready is always high and unknown indexes are dropped.
//   Each s_axis beat carries one measurement and the milliseconds since the
//   previous one; each beat yields exactly one m_axis beat with the drive.
// Sequence:
//   An accepted input beat runs the 34-step restoring divider for the
//   derivative; the ten 32x17 multiply digits of the three gain products share
//   one multiplier, the proportional and integral digits beside the divider and
//   the derivative digits after it. No new input beat is taken until then.
// Stall:
//   The result sits in an output register; a new input beat is taken while
//   it waits. A finished item holds in its last step until the register
//   frees up, and s_axis_tready stays low meanwhile.
// Reset:
//   rst_n clears the integral, the previous error and the sequencer and
//   loads the register defaults (zero gains and target, full output range,
//   largest integral limit).
// ============================================================================
`default_nettype none

module pid_controller_with_integral_clamp
    import pidc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // measured_value, elapsed_ms
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // drive_value
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [LIM_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= '0;
            cfg_reg.integ_gain     <= '0;
            cfg_reg.deriv_gain     <= '0;
            cfg_reg.out_min        <= {1'b1, {(DATA_W-1){1'b0}}};
            cfg_reg.out_max        <= {1'b0, {(DATA_W-1){1'b1}}};
            cfg_reg.integral_limit <= '1;
            cfg_reg.target         <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:  cfg_reg.prop_gain      <= cfg_data[DATA_W-1:0];
                CFG_INTEG_GAIN: cfg_reg.integ_gain     <= cfg_data[DATA_W-1:0];
                CFG_DERIV_GAIN: cfg_reg.deriv_gain     <= cfg_data[DATA_W-1:0];
                CFG_OUT_MIN:    cfg_reg.out_min        <= cfg_data[DATA_W-1:0];
                CFG_OUT_MAX:    cfg_reg.out_max        <= cfg_data[DATA_W-1:0];
                CFG_INT_LIMIT:  cfg_reg.integral_limit <= cfg_data;
                CFG_TARGET:     cfg_reg.target         <= cfg_data[DATA_W-1:0];
                default:        cfg_reg.target         <= cfg_reg.target;
            endcase
        end
    end

    pidc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pidc_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg_reg),
        .measured_value (s_axis_tdata[DATA_W-1:0]),
        .elapsed_ms     (s_axis_tdata[IN_W-1:DATA_W]),
        .sts            (sts),
        .drive_value    (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* sim/pid_drive_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// pid_drive_checker
// Watches the sample, drive and register channels of the PID controller and
// predicts every drive value with wide integer arithmetic. Each drive beat
// is compared with the oldest prediction. Mismatches, and drive beats that
// arrive with no prediction waiting, are counted and handed to the bench top.
// ============================================================================

module pid_drive_checker
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // measured_value, elapsed_ms
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,   // drive_value
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [LIM_W-1:0]  cfg_data,
    output int unsigned       pending,
    output int unsigned       mismatches
);

    localparam int unsigned PRINT_CAP = 200;

    cfg_t              regs;
    longint            integ_acc;
    longint            last_err;
    logic [DATA_W-1:0] drive_q[$];
    int unsigned       waiting = 0;
    int unsigned       fail_cnt = 0;

    assign pending    = waiting;
    assign mismatches = fail_cnt;

    task automatic report(input string msg);
        if (fail_cnt < PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
        fail_cnt++;
    endtask

    function automatic logic [DATA_W-1:0] next_drive(input logic [DATA_W-1:0] meas,
                                                     input logic [MS_W-1:0]   ms);
        longint              err;
        longint              isum;
        longint              lim;
        longint              rate;
        logic signed [127:0] pg;
        logic signed [127:0] ig;
        logic signed [127:0] dg;
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        logic signed [127:0] acc;
        err  = longint'($signed(regs.target)) - longint'($signed(meas));
        lim  = longint'(regs.integral_limit);
        isum = integ_acc + err * longint'(ms);
        if (isum > lim)
            isum = lim;
        else if (isum < -lim)
            isum = -lim;
        rate = 0;
        if (ms != '0)
            rate = (err - last_err) / longint'(ms);
        pg  = $signed(regs.prop_gain);
        ig  = $signed(regs.integ_gain);
        dg  = $signed(regs.deriv_gain);
        acc = pg * err + ig * isum + dg * rate;
        acc = acc >>> 16;
        lo  = $signed(regs.out_min);
        hi  = $signed(regs.out_max);
        if (acc < lo)
            acc = lo;
        else if (acc > hi)
            acc = hi;
        integ_acc = isum;
        last_err  = err;
        return acc[DATA_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [DATA_W-1:0] want;
        if (!rst_n)
        begin
            regs.prop_gain      = '0;
            regs.integ_gain     = '0;
            regs.deriv_gain     = '0;
            regs.out_min        = 32'h8000_0000;
            regs.out_max        = 32'h7FFF_FFFF;
            regs.integral_limit = '1;
            regs.target         = '0;
            integ_acc           = 0;
            last_err            = 0;
            drive_q.delete();
            waiting             = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:  regs.prop_gain      = cfg_data[DATA_W-1:0];
                    CFG_INTEG_GAIN: regs.integ_gain     = cfg_data[DATA_W-1:0];
                    CFG_DERIV_GAIN: regs.deriv_gain     = cfg_data[DATA_W-1:0];
                    CFG_OUT_MIN:    regs.out_min        = cfg_data[DATA_W-1:0];
                    CFG_OUT_MAX:    regs.out_max        = cfg_data[DATA_W-1:0];
                    CFG_INT_LIMIT:  regs.integral_limit = cfg_data;
                    CFG_TARGET:     regs.target         = cfg_data[DATA_W-1:0];
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = next_drive(s_axis_tdata[DATA_W-1:0], s_axis_tdata[IN_W-1:DATA_W]);
                drive_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_q.size() == 0)
                    report($sformatf("drive beat %h with no sample outstanding",
                                     m_axis_tdata));
                else
                begin
                    want = drive_q.pop_front();
                    if (m_axis_tdata !== want)
                        report($sformatf("drive_value got %h, want %h", m_axis_tdata, want));
                end
            end
            waiting = drive_q.size();
        end
    end

endmodule

/* sim/tb_pid_controller_with_integral_clamp.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_pid_controller_with_integral_clamp
// Drives register settings and measurement samples into the PID controller
// under random sender bursts and receiver stalls, including a long output
// stall that backs up the input, and reports the checker's verdict.
// ============================================================================

module tb_pid_controller_with_integral_clamp;
    import pidc_pkg::*;

    localparam logic [IDX_W-1:0] CFG_NONE    = 3'd7;
    localparam int               HOLD_CYCLES = 600;
    localparam int               BATCHES     = 10;
    localparam int               BATCH_ITEMS = 75;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;    // measured_value, elapsed_ms
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;    // drive_value
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [LIM_W-1:0]  cfg_data;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    cfg_t        cur_cfg;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pid_controller_with_integral_clamp i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pid_drive_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    // receiver: stall patterns in random spans, long hold on request
    initial
    begin
        int mode;
        int span;
        int period;
        int duty;
        m_axis_tready = 1'b0;
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 8);
            duty   = $urandom_range(1, period);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (hold_requests != holds_served)
                begin
                    holds_served++;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((k % period) < duty);
                endcase
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic cfg_t make_cfg(input logic [DATA_W-1:0] pg, input logic [DATA_W-1:0] ig,
                                      input logic [DATA_W-1:0] dg, input logic [DATA_W-1:0] lo,
                                      input logic [DATA_W-1:0] hi, input logic [LIM_W-1:0] lim,
                                      input logic [DATA_W-1:0] tgt);
        cfg_t c;
        c.prop_gain      = pg;
        c.integ_gain     = ig;
        c.deriv_gain     = dg;
        c.out_min        = lo;
        c.out_max        = hi;
        c.integral_limit = lim;
        c.target         = tgt;
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain(input int unsigned span);
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom;
            default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom;
            default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic cfg_t pick_settings();
        cfg_t              c;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        c.prop_gain  = pick_gain(32'h0004_0000);
        c.integ_gain = pick_gain(32'h0000_0100);
        c.deriv_gain = pick_gain(32'h0010_0000);
        c.target     = pick_word();
        a = pick_word();
        b = pick_word();
        case ($urandom_range(0, 3))
            0:
            begin
                c.out_min = 32'h8000_0000;
                c.out_max = 32'h7FFF_FFFF;
            end
            1:
            begin
                c.out_min = ($signed(a) < $signed(b)) ? a : b;
                c.out_max = ($signed(a) < $signed(b)) ? b : a;
            end
            2:
            begin
                c.out_min = ($signed(a) < $signed(b)) ? b : a;
                c.out_max = ($signed(a) < $signed(b)) ? a : b;
            end
            default:
            begin
                c.out_max = 32'($urandom_range(1, 32'h0040_0000));
                c.out_min = -c.out_max;
            end
        endcase
        case ($urandom_range(0, 4))
            0:       c.integral_limit = '0;
            1:       c.integral_limit = '1;
            2:       c.integral_limit = {16'($urandom), 32'($urandom)};
            default: c.integral_limit = 48'($urandom_range(0, 32'h0100_0000));
        endcase
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] pick_meas();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            default: return cur_cfg.target + 32'($urandom_range(0, 32'h0008_0000))
                            - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return '1;
            2, 3:          return 16'($urandom_range(1, 4));
            4, 5, 6, 7:    return 16'($urandom_range(1, 200));
            default:       return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input cfg_t c);
        cur_cfg = c;
        write_reg(CFG_PROP_GAIN,  {16'($urandom), c.prop_gain});
        write_reg(CFG_INTEG_GAIN, {16'($urandom), c.integ_gain});
        write_reg(CFG_DERIV_GAIN, {16'($urandom), c.deriv_gain});
        write_reg(CFG_OUT_MIN,    {16'($urandom), c.out_min});
        write_reg(CFG_OUT_MAX,    {16'($urandom), c.out_max});
        write_reg(CFG_INT_LIMIT,  c.integral_limit);
        write_reg(CFG_TARGET,     {16'($urandom), c.target});
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] meas, input logic [MS_W-1:0] ms);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ms, meas};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {16'($urandom), 32'($urandom)};
        repeat (cycles - 1) @(negedge clk);
    endtask

    // drop valid and hold until every predicted drive has come back
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic run_batch(input int count, input int gap_max, input bit with_hold);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < count)
            begin
                send_sample(pick_meas(), pick_ms());
                sent++;
                burst--;
                if (with_hold && sent == count / 2)
                    hold_requests++;
            end
            if (gap_max > 0 && sent < count)
                idle_sender($urandom_range(1, gap_max));
        end
        settle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_PROP_GAIN;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unit proportional gain, small integral and double derivative gain, moderate integral limit, full output range
        write_settings(make_cfg(32'h0001_0000, 32'h0000_0100, 32'h0002_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 48'h0001_0000_0000, 32'h0000_0000));
        send_sample(32'h8000_0000, 16'hFFFF);
        send_sample(32'h7FFF_FFFF, 16'hFFFF);
        send_sample(32'h0000_0000, 16'h0000);
        send_sample(32'hFFFF_FFFF, 16'h0001);
        send_sample(32'h0001_0000, 16'h0001);
        send_sample(32'h7FFF_FFFF, 16'h0000);
        send_sample(32'h8000_0000, 16'h0001);
        settle();

        // extreme gains, integral pinned at zero, narrow output range
        write_settings(make_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFF0_0000,
                                32'h0010_0000, 48'h0, 32'h7FFF_FFFF));
        send_sample(32'h8000_0000, 16'hFFFF);
        send_sample(32'h7FFF_FFFF, 16'h0000);
        send_sample(32'h0000_0000, 16'h0001);
        send_sample(32'h7FFF_0000, 16'h0003);
        settle();

        // inverted output bounds; the unused register index must be ignored
        write_settings(make_cfg(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                                32'hFFFF_0000, 48'hFFFF_FFFF_FFFF, 32'h8000_0000));
        write_reg(CFG_NONE, 48'hFFFF_7FFF_FFFF);
        send_sample(32'h8000_0000, 16'h0005);
        send_sample(32'h8010_0000, 16'h0005);
        send_sample(32'h0000_0000, 16'h0005);
        settle();

        // tiny gains: derivative truncation and floor rounding of the sum
        write_settings(make_cfg(32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h8000_0000,
                                32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000));
        send_sample(32'h0000_0003, 16'h0002);
        send_sample(32'hFFFF_FFFD, 16'h0002);
        send_sample(32'h0000_0005, 16'h0007);
        send_sample(32'hFFFF_FFFB, 16'h0003);
        settle();

        for (int b = 0; b < BATCHES; b++)
        begin
            write_settings(pick_settings());
            run_batch(BATCH_ITEMS, (b % 3 == 0) ? 0 : $urandom_range(2, 20),
                      (b == 2 || b == 7));
        end

        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pidc_pkg.sv
rtl/pidc_ctrl.sv
rtl/pidc_dp.sv
rtl/pid_controller_with_integral_clamp.sv
sim/pid_drive_checker.sv
sim/tb_pid_controller_with_integral_clamp.sv
